// File: src/lehmer64_bounded_random_assert.svh
// Assertion macros for the bounded Lehmer generator checker.
// Depends on nothing; included by the checker file.
`ifndef LEHMER64_BOUNDED_RANDOM_ASSERT_SVH
`define LEHMER64_BOUNDED_RANDOM_ASSERT_SVH

// Implication into the next cycle, masked during reset.
`define LBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle property");

// Implication into the next cycle, checked during reset as well.
`define LBR_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset property");

`endif

// File: src/lbr_pkg.sv
// Package for the bounded Lehmer generator: constants, state codes, seed mixer.
// Depends on nothing.
package lbr_pkg;

  localparam int unsigned WordW = 64;

  localparam logic [WordW-1:0] SEED_ZERO_SUBST = 64'h0000_0000_DEAD_C0DE;
  localparam logic [WordW-1:0] MIX_MUL_A       = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WordW-1:0] MIX_MUL_B       = 64'h94d0_49bb_1331_11eb;
  localparam logic [WordW-1:0] LEHMER_MUL      = 64'hda94_2042_e4dd_58b5;

  typedef enum logic [1:0] {
    FUNC_RESEED  = 2'd0,
    FUNC_RAW     = 2'd1,
    FUNC_BOUNDED = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b0_0000_0001,
    ST_MIX1    = 9'b0_0000_0010,
    ST_MIX2    = 9'b0_0000_0100,
    ST_RAW_LO  = 9'b0_0000_1000,
    ST_RAW_HI  = 9'b0_0001_0000,
    ST_BND_MUL = 9'b0_0010_0000,
    ST_DIV     = 9'b0_0100_0000,
    ST_CHECK   = 9'b0_1000_0000,
    ST_FINISH  = 9'b1_0000_0000
  } state_t;

  // Seed finalizer; only evaluated at elaboration for the reset state.
  function automatic logic [WordW-1:0] mix_seed(input logic [WordW-1:0] seed);
    logic [WordW-1:0] s;
    s = (seed == '0) ? SEED_ZERO_SUBST : seed;
    s = (s ^ (s >> 30)) * MIX_MUL_A;
    s = (s ^ (s >> 27)) * MIX_MUL_B;
    return s ^ (s >> 31);
  endfunction

  localparam logic [WordW-1:0] GEN_LOW_RESET = mix_seed(SEED_ZERO_SUBST);

endpackage

// File: src/lehmer64_bounded_random.sv
// Top level of the bounded 64-bit Lehmer generator with its sequencer,
// shared 32x32 multiplier and bit-serial remainder unit. Depends on lbr_pkg.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   request | in_valid in_stall in_func in_seed_value    | in
//           | in_bound                                   |
//   result  | out_valid out_stall out_value              | out
//
// Every 64x64 product runs through the one shared 32x32 multiplier. A bounded
// draw computes the rejection threshold on its first low product below the bound
// and draws again while the low product stays below that threshold; a zero bound
// and unused codes return zero without a multiply.
// Reset clears the sequencer and loads the mixed default seed; no sweep.
// A stalled result holds in the output register; a new request is taken
// once the sequencer is idle and the output register can drain.
module lehmer64_bounded_random (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [lbr_pkg::WordW-1:0] in_seed_value,
  input  logic [lbr_pkg::WordW-1:0] in_bound,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [lbr_pkg::WordW-1:0] out_value
);
  import lbr_pkg::*;

  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned AccW  = 2 * WordW;

  state_t             state_r, state_nxt;
  func_t              func_r, func_nxt;
  logic [WordW-1:0]   gen_high_r, gen_high_nxt;
  logic [WordW-1:0]   gen_low_r, gen_low_nxt;
  logic [WordW-1:0]   opa_r, opa_nxt;
  logic [WordW-1:0]   opb_r, opb_nxt;
  logic [WordW-1:0]   bound_r, bound_nxt;
  logic [AccW-1:0]    acc_r, acc_nxt;
  logic [WordW-1:0]   prod_r, prod_nxt;
  logic [1:0]         pidx_r, pidx_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [WordW-1:0]   rem_r, rem_nxt;
  logic [WordW-1:0]   dvd_r, dvd_nxt;
  logic [WordW-1:0]   thr_r, thr_nxt;
  logic               thr_valid_r, thr_valid_nxt;
  logic [WordW-1:0]   res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WordW-1:0]   out_value_r, out_value_nxt;

  logic               accept;
  logic               in_mul;
  logic               mul_done;
  logic [2:0]         sh_units;
  logic [AccW-1:0]    acc_sum;
  logic [WordW-1:0]   mix_s;
  logic [WordW-1:0]   seed_s;
  logic [WordW:0]     div_t;
  logic [WordW:0]     div_d;
  logic               out_free;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_mul   = (state_r == ST_MIX1) || (state_r == ST_MIX2) ||
                    (state_r == ST_RAW_LO) || (state_r == ST_RAW_HI) ||
                    (state_r == ST_BND_MUL);
  assign mul_done = in_mul && (cnt_r[2:0] == 3'd4);

  // Partial product weight in 32-bit units; the high state half lands at +64.
  assign sh_units = {2'b00, pidx_r[1]} + {2'b00, pidx_r[0]} +
                    ((state_r == ST_RAW_HI) ? 3'd2 : 3'd0);
  assign acc_sum  = acc_r + ({{(AccW-WordW){1'b0}}, prod_r} << (HalfW * sh_units));

  // Remainder step: shift in one dividend bit, subtract if it fits.
  assign div_t = {rem_r, dvd_r[WordW-1]};
  assign div_d = div_t - {1'b0, bound_r};

  assign seed_s = (in_seed_value == '0) ? SEED_ZERO_SUBST : in_seed_value;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    gen_high_nxt  = gen_high_r;
    gen_low_nxt   = gen_low_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    bound_nxt     = bound_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    pidx_nxt      = pidx_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    thr_nxt       = thr_r;
    thr_valid_nxt = thr_valid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    mix_s         = '0;

    // Shared multiplier: issue one partial product, fold the previous one.
    if (in_mul) begin
      if (cnt_r[2:0] != 3'd4) begin
        prod_nxt = {{HalfW{1'b0}}, (cnt_r[1] ? opa_r[WordW-1:HalfW] : opa_r[HalfW-1:0])} *
                   {{HalfW{1'b0}}, (cnt_r[0] ? opb_r[WordW-1:HalfW] : opb_r[HalfW-1:0])};
        pidx_nxt = cnt_r[1:0];
      end
      if (cnt_r[2:0] != 3'd0) begin
        acc_nxt = acc_sum;
      end
      cnt_nxt = cnt_r + 6'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt      = func_t'(in_func);
          bound_nxt     = in_bound;
          thr_valid_nxt = 1'b0;
          acc_nxt       = '0;
          cnt_nxt       = '0;
          case (func_t'(in_func))
            FUNC_RESEED: begin
              opa_nxt   = seed_s ^ (seed_s >> 30);
              opb_nxt   = MIX_MUL_A;
              state_nxt = ST_MIX1;
            end
            FUNC_RAW: begin
              opa_nxt   = gen_low_r;
              opb_nxt   = LEHMER_MUL;
              state_nxt = ST_RAW_LO;
            end
            FUNC_BOUNDED: begin
              if (in_bound == '0) begin
                res_nxt   = '0;
                state_nxt = ST_FINISH;
              end else begin
                opa_nxt   = gen_low_r;
                opb_nxt   = LEHMER_MUL;
                state_nxt = ST_RAW_LO;
              end
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_MIX1: begin
        if (mul_done) begin
          mix_s     = acc_nxt[WordW-1:0];
          opa_nxt   = mix_s ^ (mix_s >> 27);
          opb_nxt   = MIX_MUL_B;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MIX2;
        end
      end
      ST_MIX2: begin
        if (mul_done) begin
          mix_s        = acc_nxt[WordW-1:0];
          gen_low_nxt  = mix_s ^ (mix_s >> 31);
          gen_high_nxt = '0;
          res_nxt      = '0;
          state_nxt    = ST_FINISH;
        end
      end
      ST_RAW_LO: begin
        // Keep the low product and add the high half times the multiplier.
        if (mul_done) begin
          opa_nxt   = gen_high_r;
          opb_nxt   = LEHMER_MUL;
          cnt_nxt   = '0;
          state_nxt = ST_RAW_HI;
        end
      end
      ST_RAW_HI: begin
        if (mul_done) begin
          gen_high_nxt = acc_nxt[AccW-1:WordW];
          gen_low_nxt  = acc_nxt[WordW-1:0];
          if (func_r == FUNC_RAW) begin
            res_nxt   = acc_nxt[AccW-1:WordW];
            state_nxt = ST_FINISH;
          end else begin
            opa_nxt   = acc_nxt[AccW-1:WordW];
            opb_nxt   = bound_r;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_BND_MUL;
          end
        end
      end
      ST_BND_MUL: begin
        if (mul_done) begin
          if (acc_nxt[WordW-1:0] >= bound_r) begin
            res_nxt   = acc_nxt[AccW-1:WordW];
            state_nxt = ST_FINISH;
          end else if (!thr_valid_r) begin
            rem_nxt   = '0;
            dvd_nxt   = '0 - bound_r;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DIV: begin
        // Threshold (2^64 - n) mod n, one quotient bit a cycle.
        rem_nxt = div_d[WordW] ? div_t[WordW-1:0] : div_d[WordW-1:0];
        dvd_nxt = {dvd_r[WordW-2:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          thr_nxt       = rem_nxt;
          thr_valid_nxt = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (acc_r[WordW-1:0] < thr_r) begin
          // Reject: draw again from the advanced state.
          opa_nxt   = gen_low_r;
          opb_nxt   = LEHMER_MUL;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_RAW_LO;
        end else begin
          res_nxt   = acc_r[AccW-1:WordW];
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen_high_r  <= '0;
      gen_low_r   <= GEN_LOW_RESET;
      thr_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      gen_high_r  <= gen_high_nxt;
      gen_low_r   <= gen_low_nxt;
      thr_valid_r <= thr_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    bound_r     <= bound_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    pidx_r      <= pidx_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    thr_r       <= thr_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

// File: src/lbr_checker.sv
// Port-level checker for the bounded Lehmer generator, bound to the top level.
// Depends on lbr_pkg and lehmer64_bounded_random_assert.svh.
`include "lehmer64_bounded_random_assert.svh"

module lbr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [lbr_pkg::WordW-1:0] out_value
);
  import lbr_pkg::*;

  // Reset leaves no result pending.
  `LBR_ASSERT_ALWAYS(a_reset_clears, !rst_n, !out_valid)
  // A taken request keeps the block busy for at least the next cycle.
  `LBR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A stalled result stays offered and unchanged.
  `LBR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LBR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_value))

endmodule

bind lehmer64_bounded_random lbr_checker u_lbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_value (out_value)
);
